[hdl/quad_vca_cascade_mixer_top_defines.svh]
// ----------------------------------------------------------------------------
// quad vca cascade mixer assertion macros
// shared concurrent assertion forms, clocked on aclk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef QUAD_VCA_CASCADE_MIXER_TOP_DEFINES_SVH
`define QUAD_VCA_CASCADE_MIXER_TOP_DEFINES_SVH

// same-cycle implication
`define QVCM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QVCM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/qvcm_pkg.sv]
// ----------------------------------------------------------------------------
// qvcm_pkg
// shared widths, types and the exponential curve table of the vca mixer
// ----------------------------------------------------------------------------
package qvcm_pkg;

    localparam int CHANNEL_COUNT       = 4;
    localparam int SAMPLE_BITS         = 16;
    localparam int CURVE_TABLE_ENTRIES = 64;

    // configuration
    localparam int GAIN_BITS         = 17;
    localparam int UNITY_Q16         = 65536;
    localparam int CFG_COUNT         = 2 * CHANNEL_COUNT;
    localparam int CFG_IDX_BITS      = $clog2(CFG_COUNT) + 1;
    localparam int REG_GAIN_BASE     = 0;
    localparam int REG_RESPONSE_BASE = CHANNEL_COUNT;

    // control law
    localparam int LIN_BITS      = 14;
    localparam int LIN_MAX       = 8192;
    localparam int LIN_FRAC_BITS = 13;
    localparam int LIN_CV_SAT    = 20480;  // cv at which 2*cv/5 reaches 2.0
    localparam int DIV_IN_BITS   = 16;
    localparam int RECIP5        = 52429;  // ceil(2^18 / 5)
    localparam int RECIP5_SHIFT  = 18;
    localparam int IDX_BITS      = $clog2(CURVE_TABLE_ENTRIES + 1);
    localparam int POS_BITS      = LIN_FRAC_BITS + IDX_BITS;
    localparam int CURVE_BITS    = 16;
    localparam int M_BITS        = 17;
    localparam int ROUND_Q12     = 2048;
    localparam int ROUND_Q13     = 4096;
    localparam int ROUND_Q16     = 32768;

    // datapath
    localparam int GAINED_BITS = SAMPLE_BITS + GAIN_BITS - 1;
    localparam int PROD_BITS   = GAINED_BITS + M_BITS;
    localparam int SCALED_BITS = GAINED_BITS + 5;
    localparam int SUM_BITS    = SCALED_BITS + 3;
    localparam int SAMPLE_MAX  = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN  = -SAMPLE_MAX - 1;

    // stream widths
    localparam int S_TDATA_BITS = ((2 * CHANNEL_COUNT * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((CHANNEL_COUNT * SAMPLE_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS = 2 * CHANNEL_COUNT;
    localparam int M_TUSER_BITS = CHANNEL_COUNT;

    // pipeline depth
    localparam int FRONT_STAGES   = 1;
    localparam int CURVE_STAGES   = 3;
    localparam int CASCADE_STAGES = CHANNEL_COUNT + 1;
    localparam int PIPE_STAGES    = FRONT_STAGES + CURVE_STAGES + CASCADE_STAGES;

    // curve table construction
    localparam longint unsigned LN200_Q24 = 88891015;
    localparam longint unsigned ONE_Q24   = 16777216;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic        [GAIN_BITS-1:0]   coef_t;
    typedef logic        [LIN_BITS-1:0]    lin_t;
    typedef logic        [CURVE_BITS-1:0]  curve_t;
    typedef logic signed [GAINED_BITS-1:0] gained_t;
    typedef logic signed [M_BITS-1:0]      mult_t;
    typedef logic signed [SCALED_BITS-1:0] scaled_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [CHANNEL_COUNT-1:0]      mask_t;
    typedef curve_t curve_tbl_t [0:CURVE_TABLE_ENTRIES];

    // one table point: taylor series of 200^(k/N) in q24, then (e-1)*10/199 in q4.12
    function automatic curve_t curve_point(input int unsigned k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        x    = (LN200_Q24 * 64'(k)) / 64'(CURVE_TABLE_ENTRIES);
        term = ONE_Q24;
        acc  = ONE_Q24;
        for (int unsigned n = 1; n < 80; n++) begin
            if (term != 64'd0) begin
                term = ((term * x) >> 24) / 64'(n);
                acc  = acc + term;
            end
        end
        acc = ((acc - ONE_Q24) * 64'd10) / 64'd199;
        return CURVE_BITS'((acc + 64'd2048) >> 12);
    endfunction

    function automatic curve_tbl_t build_curve();
        curve_tbl_t t;
        for (int unsigned k = 0; k <= CURVE_TABLE_ENTRIES; k++) begin
            t[k] = curve_point(k);
        end
        return t;
    endfunction

    localparam curve_tbl_t CURVE_TBL = build_curve();

endpackage

[hdl/qvcm_front.sv]
// ----------------------------------------------------------------------------
// qvcm_front
// first stage: input gain multiply and linear cv term per channel
// ----------------------------------------------------------------------------
module qvcm_front (
    input  logic                   aclk,
    input  logic                   en,
    input  qvcm_pkg::sample_t      audio_in [qvcm_pkg::CHANNEL_COUNT],
    input  qvcm_pkg::sample_t      cv_in    [qvcm_pkg::CHANNEL_COUNT],
    input  qvcm_pkg::coef_t        gain     [qvcm_pkg::CHANNEL_COUNT],
    input  qvcm_pkg::mask_t        cv_mask,
    input  qvcm_pkg::mask_t        out_mask,
    output qvcm_pkg::gained_t      gained_reg [qvcm_pkg::CHANNEL_COUNT],
    output qvcm_pkg::lin_t         lin_reg    [qvcm_pkg::CHANNEL_COUNT],
    output qvcm_pkg::mask_t        cv_mask_reg,
    output qvcm_pkg::mask_t        out_mask_reg
);
    import qvcm_pkg::*;

    logic signed [31:0]              cv_w     [CHANNEL_COUNT];
    logic        [DIV_IN_BITS-1:0]   dbl      [CHANNEL_COUNT];
    logic        [2*DIV_IN_BITS-1:0] quot     [CHANNEL_COUNT];
    logic signed [GAINED_BITS+1:0]   gprod    [CHANNEL_COUNT];
    gained_t                         gained_next [CHANNEL_COUNT];
    lin_t                            lin_next    [CHANNEL_COUNT];

    always_comb begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            // gain is unsigned q1.16, product is exact
            gprod[i]       = audio_in[i] * $signed({1'b0, gain[i]});
            gained_next[i] = GAINED_BITS'(gprod[i]);

            // lin = floor(2*cv/5) via reciprocal, clamped to 2.0
            cv_w[i] = 32'(cv_in[i]);
            dbl[i]  = DIV_IN_BITS'(cv_w[i] <<< 1);
            quot[i] = (2*DIV_IN_BITS)'(dbl[i]) * (2*DIV_IN_BITS)'(RECIP5);
            if (cv_w[i] <= 0) begin
                lin_next[i] = '0;
            end else if (cv_w[i] >= LIN_CV_SAT) begin
                lin_next[i] = LIN_BITS'(LIN_MAX);
            end else begin
                lin_next[i] = LIN_BITS'(quot[i] >> RECIP5_SHIFT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gained_reg   <= gained_next;
            lin_reg      <= lin_next;
            cv_mask_reg  <= cv_mask;
            out_mask_reg <= out_mask;
        end
    end

endmodule

[hdl/qvcm_curve.sv]
// ----------------------------------------------------------------------------
// qvcm_curve
// three stages: table lookup, interpolation, linear/exponential blend
// ----------------------------------------------------------------------------
module qvcm_curve (
    input  logic                                  aclk,
    input  logic [qvcm_pkg::CURVE_STAGES-1:0]     en,
    input  qvcm_pkg::gained_t                     gained_in [qvcm_pkg::CHANNEL_COUNT],
    input  qvcm_pkg::lin_t                        lin_in    [qvcm_pkg::CHANNEL_COUNT],
    input  qvcm_pkg::mask_t                       cv_mask_in,
    input  qvcm_pkg::mask_t                       out_mask_in,
    input  qvcm_pkg::coef_t                       response  [qvcm_pkg::CHANNEL_COUNT],
    output qvcm_pkg::gained_t                     c_gained_reg [qvcm_pkg::CHANNEL_COUNT],
    output qvcm_pkg::mult_t                       c_m_reg      [qvcm_pkg::CHANNEL_COUNT],
    output qvcm_pkg::mask_t                       c_cv_mask_reg,
    output qvcm_pkg::mask_t                       c_out_mask_reg
);
    import qvcm_pkg::*;

    localparam int INTERP_BITS = CURVE_BITS + LIN_FRAC_BITS + 1;
    localparam int BLEND_BITS  = M_BITS + GAIN_BITS + 1;

    // stage a
    logic [POS_BITS-1:0]      pos    [CHANNEL_COUNT];
    logic [IDX_BITS-1:0]      idx    [CHANNEL_COUNT];
    curve_t                   t_lo   [CHANNEL_COUNT];
    curve_t                   t_hi   [CHANNEL_COUNT];
    curve_t                   a_lo_next   [CHANNEL_COUNT];
    curve_t                   a_diff_next [CHANNEL_COUNT];
    logic [LIN_FRAC_BITS-1:0] a_frac_next [CHANNEL_COUNT];
    curve_t                   a_lo_reg    [CHANNEL_COUNT];
    curve_t                   a_diff_reg  [CHANNEL_COUNT];
    logic [LIN_FRAC_BITS-1:0] a_frac_reg  [CHANNEL_COUNT];
    lin_t                     a_lin_reg   [CHANNEL_COUNT];
    gained_t                  a_gained_reg [CHANNEL_COUNT];
    mask_t                    a_cv_mask_reg;
    mask_t                    a_out_mask_reg;

    // stage b
    logic [INTERP_BITS-1:0]   interp [CHANNEL_COUNT];
    curve_t                   b_e_next [CHANNEL_COUNT];
    curve_t                   b_e_reg  [CHANNEL_COUNT];
    lin_t                     b_lin_reg [CHANNEL_COUNT];
    gained_t                  b_gained_reg [CHANNEL_COUNT];
    mask_t                    b_cv_mask_reg;
    mask_t                    b_out_mask_reg;

    // stage c
    mult_t                    diff_le [CHANNEL_COUNT];
    logic signed [BLEND_BITS-1:0] blend [CHANNEL_COUNT];
    logic signed [BLEND_BITS-1:0] blend_r [CHANNEL_COUNT];
    mult_t                    c_m_next [CHANNEL_COUNT];

    always_comb begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            pos[i]  = POS_BITS'(lin_in[i]) * POS_BITS'(CURVE_TABLE_ENTRIES);
            idx[i]  = IDX_BITS'(pos[i] >> LIN_FRAC_BITS);
            t_lo[i] = CURVE_TBL[idx[i]];
            // top end of the curve has no upper neighbor
            if (idx[i] >= IDX_BITS'(CURVE_TABLE_ENTRIES)) begin
                t_hi[i] = t_lo[i];
            end else begin
                t_hi[i] = CURVE_TBL[IDX_BITS'(idx[i] + 1'b1)];
            end
            a_lo_next[i]   = t_lo[i];
            a_diff_next[i] = t_hi[i] - t_lo[i];
            a_frac_next[i] = pos[i][LIN_FRAC_BITS-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            interp[i]   = (INTERP_BITS'(a_diff_reg[i]) * INTERP_BITS'(a_frac_reg[i])
                          + INTERP_BITS'(ROUND_Q13)) >> LIN_FRAC_BITS;
            b_e_next[i] = a_lo_reg[i] + CURVE_BITS'(interp[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            diff_le[i]  = $signed(M_BITS'(b_lin_reg[i])) - $signed(M_BITS'(b_e_reg[i]));
            blend[i]    = diff_le[i] * $signed({1'b0, response[i]});
            blend_r[i]  = (blend[i] + BLEND_BITS'(ROUND_Q16)) >>> 16;
            c_m_next[i] = $signed(M_BITS'(b_e_reg[i])) + M_BITS'(blend_r[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_lo_reg       <= a_lo_next;
            a_diff_reg     <= a_diff_next;
            a_frac_reg     <= a_frac_next;
            a_lin_reg      <= lin_in;
            a_gained_reg   <= gained_in;
            a_cv_mask_reg  <= cv_mask_in;
            a_out_mask_reg <= out_mask_in;
        end
        if (en[1]) begin
            b_e_reg        <= b_e_next;
            b_lin_reg      <= a_lin_reg;
            b_gained_reg   <= a_gained_reg;
            b_cv_mask_reg  <= a_cv_mask_reg;
            b_out_mask_reg <= a_out_mask_reg;
        end
        if (en[2]) begin
            c_m_reg        <= c_m_next;
            c_gained_reg   <= b_gained_reg;
            c_cv_mask_reg  <= b_cv_mask_reg;
            c_out_mask_reg <= b_out_mask_reg;
        end
    end

endmodule

[hdl/qvcm_cascade.sv]
// ----------------------------------------------------------------------------
// qvcm_cascade
// control multiply, then one stage per channel for the running sum and taps
// ----------------------------------------------------------------------------
module qvcm_cascade (
    input  logic                                  aclk,
    input  logic [qvcm_pkg::CASCADE_STAGES-1:0]   en,
    input  qvcm_pkg::gained_t                     gained_in [qvcm_pkg::CHANNEL_COUNT],
    input  qvcm_pkg::mult_t                       m_in      [qvcm_pkg::CHANNEL_COUNT],
    input  qvcm_pkg::mask_t                       cv_mask_in,
    input  qvcm_pkg::mask_t                       out_mask_in,
    output qvcm_pkg::sample_t                     audio_out [qvcm_pkg::CHANNEL_COUNT],
    output qvcm_pkg::mask_t                       driven_mask
);
    import qvcm_pkg::*;

    logic signed [PROD_BITS-1:0] prod  [CHANNEL_COUNT];
    logic signed [PROD_BITS-1:0] prod_r [CHANNEL_COUNT];

    scaled_t sc_next    [CASCADE_STAGES][CHANNEL_COUNT];
    sample_t out_next   [CASCADE_STAGES][CHANNEL_COUNT];
    sum_t    carry_next [CASCADE_STAGES];
    mask_t   mask_next  [CASCADE_STAGES];
    scaled_t sc_reg     [CASCADE_STAGES][CHANNEL_COUNT];
    sample_t out_reg    [CASCADE_STAGES][CHANNEL_COUNT];
    sum_t    carry_reg  [CASCADE_STAGES];
    mask_t   mask_reg   [CASCADE_STAGES];

    sum_t    acc   [CASCADE_STAGES];
    sum_t    acc_r [CASCADE_STAGES];

    always_comb begin
        // scale stage
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            prod[i]   = gained_in[i] * m_in[i];
            prod_r[i] = (prod[i] + PROD_BITS'(ROUND_Q12)) >>> 12;
            if (cv_mask_in[i]) begin
                sc_next[0][i] = SCALED_BITS'(prod_r[i]);
            end else begin
                sc_next[0][i] = SCALED_BITS'(gained_in[i]);
            end
            out_next[0][i] = '0;
        end
        carry_next[0] = '0;
        mask_next[0]  = out_mask_in;
        acc[0]        = '0;
        acc_r[0]      = '0;

        // stage s adds channel s-1 and taps it when its output is patched
        for (int s = 1; s < CASCADE_STAGES; s++) begin
            sc_next[s]   = sc_reg[s-1];
            out_next[s]  = out_reg[s-1];
            mask_next[s] = mask_reg[s-1];
            acc[s]       = carry_reg[s-1] + SUM_BITS'(sc_reg[s-1][s-1]);
            acc_r[s]     = (acc[s] + SUM_BITS'(ROUND_Q16)) >>> 16;
            if (mask_reg[s-1][s-1]) begin
                if (acc_r[s] > SAMPLE_MAX) begin
                    out_next[s][s-1] = SAMPLE_BITS'(SAMPLE_MAX);
                end else if (acc_r[s] < SAMPLE_MIN) begin
                    out_next[s][s-1] = SAMPLE_BITS'(SAMPLE_MIN);
                end else begin
                    out_next[s][s-1] = SAMPLE_BITS'(acc_r[s]);
                end
                carry_next[s] = '0;
            end else begin
                carry_next[s] = acc[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < CASCADE_STAGES; s++) begin
            if (en[s]) begin
                sc_reg[s]    <= sc_next[s];
                out_reg[s]   <= out_next[s];
                carry_reg[s] <= carry_next[s];
                mask_reg[s]  <= mask_next[s];
            end
        end
    end

    assign audio_out   = out_reg[CASCADE_STAGES-1];
    assign driven_mask = mask_reg[CASCADE_STAGES-1];

endmodule

[hdl/quad_vca_cascade_mixer_top.sv]
// ----------------------------------------------------------------------------
// quad_vca_cascade_mixer_top
// four cv-controlled amplifiers whose mixes cascade into the next output
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: audio 0..3, cv 0..3; tuser: cv mask, out mask
// m_        out  m_tvalid/m_tready  tdata: audio out 0..3; tuser: driven mask
// cfg_      in   cfg_wr_en          cfg_addr, cfg_wdata (gain 0..3, response 0..3)
//
// one request enters per cycle unless every stage is full and the output stalls
// stages: front 1, curve 3, scale 1 and one per channel for the serial chain of adds
// reset clears the valid bits and loads gain 0 and response unity
// each stage holds when it is full and the stage after it does not move, so a
// stalled output still lets bubbles upstream close up and input keep flowing
// configuration registers are read directly by the datapath; the user must write them
// only while idle, which the block itself does not enforce
`include "quad_vca_cascade_mixer_top_defines.svh"

module quad_vca_cascade_mixer_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [qvcm_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
    input  logic [qvcm_pkg::GAIN_BITS-1:0]        cfg_wdata,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // audio_in_0..3, cv_in_0..3 (from bit 0 up), zero padded
    input  logic [qvcm_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // cv_connected_mask, out_connected_mask (from bit 0 up)
    input  logic [qvcm_pkg::S_TUSER_BITS-1:0]     s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // audio_out_0..3 (from bit 0 up), zero padded
    output logic [qvcm_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // out_driven_mask
    output logic [qvcm_pkg::M_TUSER_BITS-1:0]     m_tuser
);
    import qvcm_pkg::*;

    // configuration registers, writes above unity clamp to unity
    coef_t gain_reg      [CHANNEL_COUNT];
    coef_t gain_next     [CHANNEL_COUNT];
    coef_t response_reg  [CHANNEL_COUNT];
    coef_t response_next [CHANNEL_COUNT];
    coef_t cfg_val;

    // pipeline occupancy and per-stage advance
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] stage_en;

    // unpacked stream fields
    sample_t audio_in  [CHANNEL_COUNT];
    sample_t cv_in     [CHANNEL_COUNT];
    sample_t audio_out [CHANNEL_COUNT];
    mask_t   cv_mask;
    mask_t   out_mask;
    mask_t   driven_mask;

    // stage to stage
    gained_t f_gained [CHANNEL_COUNT];
    lin_t    f_lin    [CHANNEL_COUNT];
    mask_t   f_cv_mask;
    mask_t   f_out_mask;
    gained_t c_gained [CHANNEL_COUNT];
    mult_t   c_m      [CHANNEL_COUNT];
    mask_t   c_cv_mask;
    mask_t   c_out_mask;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_comb begin
        cfg_val = (cfg_wdata > GAIN_BITS'(UNITY_Q16)) ? GAIN_BITS'(UNITY_Q16) : cfg_wdata;
        gain_next     = gain_reg;
        response_next = response_reg;
        if (cfg_wr_en) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                if (cfg_addr == CFG_IDX_BITS'(REG_GAIN_BASE + i)) begin
                    gain_next[i] = cfg_val;
                end
                if (cfg_addr == CFG_IDX_BITS'(REG_RESPONSE_BASE + i)) begin
                    response_next[i] = cfg_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                gain_reg[i]     <= '0;
                response_reg[i] <= GAIN_BITS'(UNITY_Q16);
            end
        end else begin
            gain_reg     <= gain_next;
            response_reg <= response_next;
        end
    end

    // ------------------------------------------------------------------
    // handshake: a stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------
    always_comb begin
        stage_en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    // ------------------------------------------------------------------
    // field unpacking and packing
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            audio_in[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            cv_in[i]    = s_tdata[(CHANNEL_COUNT+i)*SAMPLE_BITS +: SAMPLE_BITS];
        end
        cv_mask  = s_tuser[CHANNEL_COUNT-1:0];
        out_mask = s_tuser[2*CHANNEL_COUNT-1:CHANNEL_COUNT];
    end

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            m_tdata[i*SAMPLE_BITS +: SAMPLE_BITS] = audio_out[i];
        end
    end

    assign m_tuser = driven_mask;

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    // gain multiply and linear cv term
    qvcm_front u_front (
        .aclk         (aclk),
        .en           (stage_en[0]),
        .audio_in     (audio_in),
        .cv_in        (cv_in),
        .gain         (gain_reg),
        .cv_mask      (cv_mask),
        .out_mask     (out_mask),
        .gained_reg   (f_gained),
        .lin_reg      (f_lin),
        .cv_mask_reg  (f_cv_mask),
        .out_mask_reg (f_out_mask)
    );

    // curve lookup, interpolation and response blend
    qvcm_curve u_curve (
        .aclk           (aclk),
        .en             (stage_en[FRONT_STAGES +: CURVE_STAGES]),
        .gained_in      (f_gained),
        .lin_in         (f_lin),
        .cv_mask_in     (f_cv_mask),
        .out_mask_in    (f_out_mask),
        .response       (response_reg),
        .c_gained_reg   (c_gained),
        .c_m_reg        (c_m),
        .c_cv_mask_reg  (c_cv_mask),
        .c_out_mask_reg (c_out_mask)
    );

    // control multiply and output cascade; last stage is the output register
    qvcm_cascade u_cascade (
        .aclk        (aclk),
        .en          (stage_en[FRONT_STAGES+CURVE_STAGES +: CASCADE_STAGES]),
        .gained_in   (c_gained),
        .m_in        (c_m),
        .cv_mask_in  (c_cv_mask),
        .out_mask_in (c_out_mask),
        .audio_out   (audio_out),
        .driven_mask (driven_mask)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // input is refused only when every stage holds a request
    `QVCM_ASSERT_IMP(a_blocked_only_when_full, !s_tready, &valid_reg, "input blocked with a bubble")

    // an accepted request always lands in the first stage
    `QVCM_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, valid_reg[0], "request lost at entry")

    // an output that was not tapped carries zero
    for (genvar gi = 0; gi < CHANNEL_COUNT; gi++) begin : g_chk
        `QVCM_ASSERT_IMP(a_undriven_zero, m_tvalid && !m_tuser[gi], audio_out[gi] == '0, "undriven output not zero")
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quad vca cascade mixer: frames are streamed in
// under random idling and stalls, each accepted request is run through a local
// fixed-point model of the four amplifiers and the cascade, and every result
// is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qvcm_pkg::*;

    // bench knobs
    localparam int IDLE_PCT       = 7;      // chance per cycle that a side rests
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no request moving
    localparam int SHOWN_ERRORS   = 10;
    localparam int DRAIN_CYCLES   = 2 * PIPE_STAGES + 8;
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off

    // arithmetic of the control law, kept local to the model
    localparam logic [63:0] EXPO_LN200 = 64'd88891015;  // ln 200 in q24
    localparam logic [63:0] EXPO_ONE   = 64'd16777216;  // 1.0 in q24
    localparam longint      LIN_FULL   = 8192;          // lin of 2.0 in q4.12
    localparam longint      MIX_MAX    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint      MIX_MIN    = -MIX_MAX - 1;
    localparam logic [GAIN_BITS-1:0] UNITY_COEF = 17'h10000;
    localparam int          LAST_ADDR  = (1 << CFG_IDX_BITS) - 1;

    // one input frame; packed so that {cv, audio} is the tdata layout
    typedef struct packed {
        mask_t             out_mask;
        mask_t             cv_mask;
        sample_t [CHANNEL_COUNT-1:0] cv;
        sample_t [CHANNEL_COUNT-1:0] audio;
    } frame_t;

    // one result frame
    typedef struct packed {
        mask_t             driven;
        sample_t [CHANNEL_COUNT-1:0] mix;
    } mix_frame_t;

    // how a register value is picked for a settings phase
    typedef enum int {
        COEF_ZERO,
        COEF_UNITY,
        COEF_OVER,
        COEF_ANY,
        COEF_MIXED
    } coef_style_e;

    // ------------------------------------------------------------------------
    // dut signals, inputs all at a known value from time zero
    // ------------------------------------------------------------------------
    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_addr  = '0;
    logic [GAIN_BITS-1:0]      cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata   = '0;
    logic [S_TUSER_BITS-1:0]   s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic [M_TUSER_BITS-1:0]   m_tuser;

    // ------------------------------------------------------------------------
    // model state: register copies and the expo curve
    // ------------------------------------------------------------------------
    longint     gain_q16 [CHANNEL_COUNT];
    longint     resp_q16 [CHANNEL_COUNT];
    longint     expo_curve [0:CURVE_TABLE_ENTRIES];

    mix_frame_t mix_due_q [$];      // predicted results, oldest first
    int         error_count  = 0;
    int         stuck_cycles = 0;
    int         rx_hold_left = 0;   // receiver hold-off, counted down by the receiver
    bit         steady_flow  = 1'b0; // no idling on either side while set
    mix_frame_t got_frame;
    mix_frame_t want_frame;

    quad_vca_cascade_mixer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // audio_in_0..3, cv_in_0..3 from bit 0 up
        .s_tuser   (s_tuser),   // cv_connected_mask, out_connected_mask
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // audio_out_0..3 from bit 0 up
        .m_tuser   (m_tuser)    // out_driven_mask
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // fixed-point model of the mixer
    // ------------------------------------------------------------------------

    // round half up, then drop s bits
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // expo at lin = 2k/N: taylor series of 200^(k/N) in q24, then (e-1)*10/199
    function automatic longint expo_point(int unsigned k);
        logic [63:0] arg;
        logic [63:0] term;
        logic [63:0] acc;
        int unsigned n;
        arg  = (EXPO_LN200 * 64'(k)) / 64'(CURVE_TABLE_ENTRIES);
        term = EXPO_ONE;
        acc  = EXPO_ONE;
        n    = 1;
        while (n < 80 && term != 64'd0) begin
            term = ((term * arg) >> 24) / 64'(n);
            acc  = acc + term;
            n++;
        end
        acc = ((acc - EXPO_ONE) * 64'd10) / 64'd199;
        return longint'((acc + 64'd2048) >> 12);
    endfunction

    // control multiplier in q4.12: blend of the interpolated expo curve and lin
    function automatic longint control_gain(longint cv, longint resp);
        longint lin;
        longint pos;
        longint seg;
        longint frac;
        longint e;
        if (cv <= 0) begin
            lin = 0;
        end else begin
            lin = (cv * 2) / 5;
            if (lin > LIN_FULL) lin = LIN_FULL;
        end
        pos  = lin * CURVE_TABLE_ENTRIES;
        seg  = pos / LIN_FULL;
        frac = pos % LIN_FULL;
        if (seg >= CURVE_TABLE_ENTRIES) begin
            e = expo_curve[CURVE_TABLE_ENTRIES];
        end else begin
            e = expo_curve[seg]
                + (((expo_curve[seg + 1] - expo_curve[seg]) * frac + 4096) >>> 13);
        end
        return e + round_shift((lin - e) * resp, 16);
    endfunction

    // the whole frame: per-channel scaling, running sum, tap at patched outputs
    function automatic mix_frame_t predict_mix(frame_t f);
        mix_frame_t r;
        longint     acc;
        longint     part;
        longint     y;
        r   = '0;
        acc = 0;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            part = longint'($signed(f.audio[ch])) * gain_q16[ch];
            if (f.cv_mask[ch]) begin
                part = round_shift(part * control_gain(longint'($signed(f.cv[ch])),
                                                       resp_q16[ch]), 12);
            end
            acc = acc + part;
            if (f.out_mask[ch]) begin
                y = round_shift(acc, 16);
                if (y > MIX_MAX) y = MIX_MAX;
                if (y < MIX_MIN) y = MIX_MIN;
                r.mix[ch] = sample_t'(y);
                acc = 0;
            end
        end
        r.driven = f.out_mask;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic note_error(string what, longint want, longint got);
        if (error_count < SHOWN_ERRORS) begin
            $display("tb: mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        end
        error_count++;
    endtask

    // every result request is compared with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_frame.mix    = m_tdata[CHANNEL_COUNT*SAMPLE_BITS-1:0];
            got_frame.driven = m_tuser;
            if (mix_due_q.size() == 0) begin
                note_error("result with nothing pending, driven mask", -1, got_frame.driven);
            end else begin
                want_frame = mix_due_q.pop_front();
                for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                    if (got_frame.mix[ch] !== want_frame.mix[ch]) begin
                        note_error($sformatf("audio_out_%0d", ch),
                                   $signed(want_frame.mix[ch]), $signed(got_frame.mix[ch]));
                    end
                end
                if (got_frame.driven !== want_frame.driven) begin
                    note_error("out_driven_mask", want_frame.driven, got_frame.driven);
                end
            end
        end
    end

    // receiver: random stalls, a steady stretch, and a long counted hold-off
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: ends the run when no request moves for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one input request; the prediction is queued at the accepting edge
    task automatic send_frame(frame_t f);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'({f.cv, f.audio});
        s_tuser  <= {f.out_mask, f.cv_mask};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mix_due_q.push_back(predict_mix(f));
    endtask

    // drop valid after the last request of a test
    task automatic stream_end();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // every frame gives a result, so an empty queue means the pipe is empty
    task automatic wait_idle();
        while (mix_due_q.size() != 0) @(posedge aclk);
    endtask

    // one register write; the caller drops the enable after a burst
    task automatic write_reg(int idx, logic [GAIN_BITS-1:0] val);
        longint v;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_IDX_BITS'(idx);
        cfg_wdata <= val;
        @(posedge aclk);
        v = (val > UNITY_COEF) ? longint'(UNITY_COEF) : longint'(val);
        if (idx >= REG_GAIN_BASE && idx < REG_GAIN_BASE + CHANNEL_COUNT) begin
            gain_q16[idx - REG_GAIN_BASE] = v;
        end else if (idx >= REG_RESPONSE_BASE && idx < REG_RESPONSE_BASE + CHANNEL_COUNT) begin
            resp_q16[idx - REG_RESPONSE_BASE] = v;
        end
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [GAIN_BITS-1:0] pick_coef(coef_style_e sty);
        coef_style_e s;
        s = sty;
        if (s == COEF_MIXED) s = coef_style_e'($urandom_range(COEF_ANY));
        case (s)
            COEF_ZERO:  return '0;
            COEF_UNITY: return UNITY_COEF;
            COEF_OVER:  return GAIN_BITS'($urandom_range(UNITY_COEF + 1, (1 << GAIN_BITS) - 1));
            default:    return GAIN_BITS'($urandom_range(UNITY_COEF));
        endcase
    endfunction

    task automatic program_regs(coef_style_e gain_sty, coef_style_e resp_sty);
        wait_idle();
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            write_reg(REG_GAIN_BASE + ch, pick_coef(gain_sty));
        end
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            write_reg(REG_RESPONSE_BASE + ch, pick_coef(resp_sty));
        end
        end_writes();
    endtask

    // same sample and cv on all four channels
    function automatic frame_t uniform_frame(sample_t a, sample_t cv, mask_t cvm, mask_t outm);
        frame_t f;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            f.audio[ch] = a;
            f.cv[ch]    = cv;
        end
        f.cv_mask  = cvm;
        f.out_mask = outm;
        return f;
    endfunction

    // random content; cv leans toward the live 0..10 V span of the curve
    function automatic frame_t random_frame();
        frame_t f;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            case ($urandom_range(7))
                0:       f.audio[ch] = sample_t'(MIX_MAX);
                1:       f.audio[ch] = sample_t'(MIX_MIN);
                default: f.audio[ch] = sample_t'($urandom);
            endcase
            case ($urandom_range(3))
                0:       f.cv[ch] = sample_t'($urandom);
                1:       f.cv[ch] = sample_t'($urandom_range(24)) - sample_t'(8);
                default: f.cv[ch] = sample_t'($urandom_range(20600));
            endcase
        end
        f.cv_mask  = mask_t'($urandom);
        f.out_mask = mask_t'($urandom);
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // registers straight out of reset: zero gain mutes every output
    task automatic test_reset_state();
        for (int i = 0; i < 4; i++) send_frame(random_frame());
        send_frame(uniform_frame(sample_t'(MIX_MAX), sample_t'(MIX_MAX), '1, '1));
        stream_end();
    endtask

    // field extremes, cv clamping, patching cases and saturation
    task automatic test_directed();
        wait_idle();
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) write_reg(REG_GAIN_BASE + ch, UNITY_COEF);
        write_reg(REG_RESPONSE_BASE + 0, '0);              // pure exponential
        write_reg(REG_RESPONSE_BASE + 1, UNITY_COEF);      // pure linear
        write_reg(REG_RESPONSE_BASE + 2, 17'h08000);       // halfway
        write_reg(REG_RESPONSE_BASE + 3, 17'h0ffff);
        end_writes();
        // cv at exactly full scale, above it, negative, zero and tiny
        send_frame(uniform_frame(sample_t'(MIX_MAX), 16'sd20480, '1, '1));
        send_frame(uniform_frame(sample_t'(MIX_MIN), 16'sd20480, '1, '1));
        send_frame(uniform_frame(sample_t'(MIX_MAX), 16'sd20481, '1, '1));
        send_frame(uniform_frame(sample_t'(MIX_MAX), sample_t'(MIX_MAX), '1, '1));
        send_frame(uniform_frame(sample_t'(MIX_MIN), sample_t'(MIX_MIN), '1, '1));
        send_frame(uniform_frame(16'sd12345, -16'sd1, '1, '1));
        send_frame(uniform_frame(16'sd12345, 16'sd0, '1, '1));
        send_frame(uniform_frame(-16'sd1, 16'sd1, '1, '1));
        send_frame(uniform_frame(16'sd1000, 16'sd10240, '1, '1));
        send_frame(uniform_frame(-16'sd7777, 16'sd321, '1, '1));
        // unpatched cv: plain gain
        send_frame(uniform_frame(sample_t'(MIX_MAX), 16'sd0, '0, '1));
        send_frame(uniform_frame(16'sd1, 16'sd0, '0, '1));
        send_frame(uniform_frame(16'sd0, 16'sd0, '0, '1));
        // whole cascade into the last jack, both rails
        send_frame(uniform_frame(sample_t'(MIX_MAX), 16'sd20480, '0, 4'b1000));
        send_frame(uniform_frame(sample_t'(MIX_MIN), 16'sd20480, '0, 4'b1000));
        // last output unpatched: the rest of the sum is lost
        send_frame(uniform_frame(16'sd20000, 16'sd0, '0, 4'b0111));
        send_frame(uniform_frame(16'sd20000, 16'sd0, '0, 4'b0000));
        send_frame(uniform_frame(sample_t'(MIX_MIN), 16'sd0, 4'b0101, 4'b1010));
        send_frame(uniform_frame(-16'sd2, 16'sd5000, 4'b0101, 4'b1001));
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            send_frame(uniform_frame(16'sd16384, 16'sd15000, mask_t'(1 << ch), mask_t'(1 << ch)));
        end
        stream_end();
    endtask

    // over-range values clamp to unity; writes past the last register do nothing
    task automatic test_register_writes();
        wait_idle();
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            write_reg(REG_GAIN_BASE + ch, '1);
            write_reg(REG_RESPONSE_BASE + ch, UNITY_COEF + 17'd1);
        end
        write_reg(CFG_COUNT, '0);
        write_reg(LAST_ADDR, '0);
        end_writes();
        for (int i = 0; i < 20; i++) send_frame(random_frame());
        stream_end();
        program_regs(COEF_ANY, COEF_ZERO);
        wait_idle();
        write_reg(CFG_COUNT, '1);
        write_reg(LAST_ADDR, 17'h0a5a5);
        end_writes();
        for (int i = 0; i < 20; i++) send_frame(random_frame());
        stream_end();
    endtask

    // random traffic across several register settings, extremes included
    task automatic test_random_settings();
        coef_style_e gain_sty [6] = '{COEF_ZERO, COEF_UNITY, COEF_UNITY,
                                      COEF_ANY, COEF_MIXED, COEF_OVER};
        coef_style_e resp_sty [6] = '{COEF_ANY, COEF_UNITY, COEF_ZERO,
                                      COEF_ANY, COEF_MIXED, COEF_MIXED};
        for (int ph = 0; ph < 6; ph++) begin
            program_regs(gain_sty[ph], resp_sty[ph]);
            for (int i = 0; i < 130; i++) send_frame(random_frame());
            stream_end();
        end
    endtask

    // receiver holds off while requests keep coming, so the pipe fills and stalls
    task automatic test_backpressure();
        program_regs(COEF_MIXED, COEF_MIXED);
        rx_hold_left = HOLD_CYCLES;
        for (int i = 0; i < 80; i++) send_frame(random_frame());
        stream_end();
    endtask

    // back-to-back requests with no idling on either side
    task automatic test_steady_stream();
        program_regs(COEF_ANY, COEF_ANY);
        steady_flow = 1'b1;
        for (int i = 0; i < 150; i++) send_frame(random_frame());
        stream_end();
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    initial begin
        for (int k = 0; k <= CURVE_TABLE_ENTRIES; k++) expo_curve[k] = expo_point(k);
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            gain_q16[ch] = 0;
            resp_q16[ch] = UNITY_COEF;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_directed();
        test_register_writes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        // let the pipe empty, then a little longer to catch stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && mix_due_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
